[rtl/core/iwsm_pkg.sv]
// Package for the interferer window sample mapper.
// Shared constants, register indexes and entry types; no dependencies.
package iwsm_pkg;
   localparam int MaxEntries = 64;
   localparam int IdxBits = 6;
   localparam int TimeBits = 48;
   localparam int CsrAddrBits = 3;

   localparam logic [CsrAddrBits-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CsrAddrBits-1:0] CSR_COUNT  = 3'd1;
   localparam logic [CsrAddrBits-1:0] CSR_AMPL   = 3'd2;
   localparam logic [CsrAddrBits-1:0] CSR_WINDOW = 3'd3;
   localparam logic [CsrAddrBits-1:0] CSR_PULSE  = 3'd4;
   localparam logic [CsrAddrBits-1:0] CSR_RATE   = 3'd5;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef struct packed {
      logic [15:0] angle;
      logic [23:0] distance;
      logic [31:0] period;
   } entry_type;

   typedef struct packed {
      logic        enable;
      logic [6:0]  entry_count;
      logic [15:0] amplitude;
      logic [31:0] window;
      logic [31:0] pulse;
      logic [31:0] rate;
   } cfg_type;
endpackage

[rtl/core/iwsm_table.sv]
// Interferer table: one synchronous memory of entries with a registered read.
// Valid bits give all-zero entries after reset. Uses iwsm_pkg.
module iwsm_table (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [iwsm_pkg::IdxBits-1:0] wr_addr,
   input  iwsm_pkg::entry_type     wr_data,
   input  logic                    rd_en,
   input  logic [iwsm_pkg::IdxBits-1:0] rd_addr,
   output iwsm_pkg::entry_type     rd_data
);
   import iwsm_pkg::*;

   entry_type mem [MaxEntries];
   logic [MaxEntries-1:0] valid_ff;
   entry_type rd_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;
endmodule

[rtl/core/iwsm_divider.sv]
// Iterative remainder unit: 48-bit dividend mod 32-bit divisor, one bit a cycle.
// Depends on iwsm_pkg.
module iwsm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [iwsm_pkg::TimeBits-1:0] dividend,
   input  logic [31:0]                   divisor,
   output logic                          done,
   output logic [31:0]                   remainder
);
   import iwsm_pkg::*;
   localparam int CntBits = $clog2(TimeBits + 1);

   logic [TimeBits-1:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [32:0] shifted;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[31:0], num_ff[TimeBits-1]};
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         cnt_in = CntBits'(TimeBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[TimeBits-2:0], 1'b0};
         rem_in = (shifted >= {1'b0, div_ff}) ? shifted - {1'b0, div_ff} : shifted;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   assign done = busy_ff && (cnt_ff == CntBits'(1));
   assign remainder = rem_in[31:0];
endmodule

[rtl/core/iwsm_sampler.sv]
// Sample index unit: |rem - (window - pulse)| times Q16.16 rate, floored and
// saturated to 32 bits, accumulated from four 17x16 partial products.
module iwsm_sampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] rem,
   input  logic [31:0] window,
   input  logic [31:0] pulse,
   input  logic [31:0] rate,
   output logic        done,
   output logic [31:0] sample
);
   logic [33:0] offset, diff;
   logic [32:0] mag_in, mag_ff;
   logic [31:0] rate_ff;
   logic [2:0] step_ff;
   logic busy_ff;
   logic [65:0] acc_ff;
   logic [32:0] part;
   logic [15:0] rpart;
   logic [48:0] prod;

   always_comb begin
      offset = {2'b0, window} - {2'b0, pulse};
      diff = {2'b0, rem} - offset;
      mag_in = diff[33] ? 33'(-diff) : diff[32:0];
      part = step_ff[0] ? {16'b0, mag_ff[32:16]} : {17'b0, mag_ff[15:0]};
      rpart = step_ff[1] ? rate_ff[31:16] : rate_ff[15:0];
      prod = part[16:0] * rpart;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag_in;
         rate_ff <= rate;
         acc_ff <= '0;
      end else if (busy_ff && !step_ff[2]) begin
         acc_ff <= acc_ff + (66'(prod) << (16 * ({1'b0, step_ff[0]} + {1'b0, step_ff[1]})));
      end
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == 3'd4) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done = busy_ff && (step_ff == 3'd4);
   assign sample = (acc_ff[65:48] != '0) ? 32'hFFFF_FFFF : acc_ff[47:16];
endmodule

[rtl/core/interferer_window_sample_mapper.sv]
// Interferer window sample mapper: a write word loads one table entry and
// gives nothing; a tick word gives one result per entry up to entry_count
// (at most 64), in index order, last marked by tlast. An entry inside the
// window goes through a table read, taking the entry, starting and running
// the bit-serial remainder unit, the sample multiplier and the hand-off.
// An entry outside the window skips the multiplier, an inactive or disabled
// entry skips both units, and a tick takes longer while rsp_tready holds a
// result back. The input is taken only between ticks. After reset the table
// reads as all zeros.
module interferer_window_sample_mapper (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode, entry_index, entry_angle, entry_distance, entry_period_ns, time_ns
   input  logic [127:0] req_tdata,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic         rsp_tlast,
   // out_index, out_amplitude, out_angle, out_distance, sample_index
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [iwsm_pkg::CsrAddrBits-1:0] csr_index,
   input  logic [31:0]  csr_wdata
);
   import iwsm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   cfg_type cfg_ff;
   logic [2:0] state_ff;
   logic [IdxBits-1:0] idx_ff;
   logic [6:0] count_ff;
   logic [TimeBits-1:0] time_ff;
   entry_type ent_ff;
   logic [95:0] data_ff;
   logic last_ff;
   logic ovalid_ff;
   logic div_busy_ff;
   logic [31:0] rem_ff;
   logic rd_pend_ff;
   logic mul_seen_ff;

   logic req_acc, rd_en, out_fire;
   entry_type wr_data, rd_data;
   logic div_start, div_done, mul_start, mul_done;
   logic [31:0] rem, sample;
   logic active, inwin;
   logic [6:0] n_lim;

   assign req_acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign wr_data = '{angle: req_tdata[22:7], distance: req_tdata[46:23],
                      period: req_tdata[78:47]};
   assign n_lim = (cfg_ff.entry_count > 7'(MaxEntries)) ? 7'(MaxEntries)
                                                        : cfg_ff.entry_count;
   assign rd_en = (state_ff == ST_READ);
   assign active = cfg_ff.enable && (ent_ff.period != '0);
   assign div_start = (state_ff == ST_DIV) && !rd_pend_ff && active && !div_busy_ff;
   assign out_fire = (state_ff == ST_OUT) && (!ovalid_ff || rsp_tready);

   iwsm_table u_table (
      .clock, .reset,
      .wr_en(req_acc && req_tdata[0] == MODE_WRITE),
      .wr_addr(req_tdata[6:1]), .wr_data,
      .rd_en, .rd_addr(idx_ff), .rd_data
   );

   iwsm_divider u_div (
      .clock, .reset, .start(div_start), .dividend(time_ff),
      .divisor(ent_ff.period), .done(div_done), .remainder(rem)
   );

   assign inwin = rem_ff < cfg_ff.window;
   assign mul_start = (state_ff == ST_MUL) && !mul_seen_ff && inwin;

   iwsm_sampler u_mul (
      .clock, .reset, .start(mul_start), .rem(rem_ff),
      .window(cfg_ff.window), .pulse(cfg_ff.pulse), .rate(cfg_ff.rate),
      .done(mul_done), .sample
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: cfg_ff.enable <= csr_wdata[0];
            CSR_COUNT:  cfg_ff.entry_count <= csr_wdata[6:0];
            CSR_AMPL:   cfg_ff.amplitude <= csr_wdata[15:0];
            CSR_WINDOW: cfg_ff.window <= csr_wdata;
            CSR_PULSE:  cfg_ff.pulse <= csr_wdata;
            CSR_RATE:   cfg_ff.rate <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         time_ff <= req_tdata[126:79];
      end
      if (rd_pend_ff) begin
         ent_ff <= rd_data;
      end
      if (div_done) begin
         rem_ff <= rem;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         count_ff <= '0;
         ovalid_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (out_fire) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_tdata[0] == MODE_TICK && n_lim != '0) begin
                  idx_ff <= '0;
                  count_ff <= n_lim;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_DIV;
            ST_DIV: begin
               if (rd_pend_ff) begin
                  state_ff <= ST_DIV;
               end else if (!active) begin
                  rem_ff <= cfg_ff.window;
                  state_ff <= ST_OUT;
               end else if (!div_busy_ff) begin
                  div_busy_ff <= 1'b1;
               end else if (div_done) begin
                  div_busy_ff <= 1'b0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (!inwin) begin
                  state_ff <= ST_OUT;
               end else if (mul_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_fire) begin
                  last_ff <= (count_ff == 7'd1);
                  count_ff <= count_ff - 1'b1;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= (count_ff == 7'd1) ? ST_IDLE : ST_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || state_ff != ST_MUL) begin
         mul_seen_ff <= 1'b0;
      end else if (mul_start) begin
         mul_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         if (active && inwin) begin
            data_ff <= {2'b0, sample, ent_ff.distance, ent_ff.angle,
                        cfg_ff.amplitude, idx_ff[5:0]};
         end else begin
            data_ff <= {90'b0, idx_ff[5:0]};
         end
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = data_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_div_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("remainder outside divide");
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> count_ff != '0) else $error("result beyond count");
   a_mul_once: assert property (@(posedge clock) disable iff (reset)
      mul_seen_ff |-> !mul_start) else $error("second multiply start");
endmodule
